// ===== rtl/wdd_pkg.sv =====
// ----------------------------------------------------------------------------
// wdd_pkg: shared types for the waypoint dwell detector
// Status codes, register indexes and the item/result records passed between
// the distance stage and the dwell tracker.
// ----------------------------------------------------------------------------
package wdd_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_CENTER_Z   = 3'd2;
    localparam logic [2:0] REG_RADIUS     = 3'd3;
    localparam logic [2:0] REG_HOLD_TIME  = 3'd4;
    localparam logic [2:0] REG_START_TIME = 3'd5;

    // Operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        ST_OUTSIDE  = 3'd0,
        ST_INSIDE   = 3'd1,
        ST_FINISHED = 3'd2,
        ST_INVALID  = 3'd3,
        ST_CLEARED  = 3'd4
    } wdd_status_t;

    // One item after the distance stage
    typedef struct packed {
        logic        operation;
        logic        sample_valid;
        logic [31:0] sample_time;
        logic [43:0] dist_squared;
        logic [32:0] elapsed;
    } wdd_item_t;

    // One result item
    typedef struct packed {
        logic        reached;
        wdd_status_t status;
        logic [43:0] dist_squared;
        logic [33:0] hold_remaining;
        logic [32:0] elapsed;
        logic [32:0] finish_time;
    } wdd_result_t;

endpackage

// ===== rtl/waypoint_dwell_detector_unit.sv =====
// ----------------------------------------------------------------------------
// waypoint_dwell_detector_unit: sphere test and dwell timer for pose samples
// Tests each position sample against a configured sphere and reports when
// the position has stayed inside for the configured hold time.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the output side does not stall
// and returns one result item for each, in order. The pipeline has three
// registers: the input register, the distance register (three parallel
// 22x22 squarings and their sum) and the result register, whose next value
// comes from the dwell tracker, where the only item-to-item state lives, so
// back-to-back items need no bubbles. The squared radius is computed once
// when the radius register is written. Configuration writes take effect on
// the next clock and are meant to be made while no item is in flight. A
// clear item zeroes the finish latch and returns an all-zero result with
// status cleared; the dwell timer keeps running. The input side stalls only
// when the result register is full and not taken.
module waypoint_dwell_detector_unit (
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    // sample stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[20:0], pos_y[41:21], pos_z[62:42], sample_time[94:63], zero[95]
    input  logic [95:0]  s_tdata,
    // operation[0], sample_valid[1]
    input  logic [1:0]   s_tuser,
    // result stream out
    output logic         m_tvalid,
    input  logic         m_tready,
    // dist_squared[43:0], hold_remaining[77:44], elapsed[110:78],
    // finish_time[143:111]
    output logic [143:0] m_tdata,
    // reached[0], status[3:1]
    output logic [3:0]   m_tuser
);

    // configuration registers
    logic signed [20:0] center_x_reg;
    logic signed [20:0] center_y_reg;
    logic signed [20:0] center_z_reg;
    logic [39:0]        radius_sq_reg;
    logic [23:0]        hold_time_reg;
    logic [31:0]        start_time_reg;

    // input register
    logic               s1_valid_reg;
    logic               s1_op_reg;
    logic               s1_smp_valid_reg;
    logic signed [20:0] s1_x_reg;
    logic signed [20:0] s1_y_reg;
    logic signed [20:0] s1_z_reg;
    logic [31:0]        s1_time_reg;

    // distance register
    logic               s2_valid_reg;
    wdd_pkg::wdd_item_t s2_item_reg;
    wdd_pkg::wdd_item_t s2_item_next;

    // result register
    logic                 out_valid_reg;
    wdd_pkg::wdd_result_t out_res_reg;
    wdd_pkg::wdd_result_t out_res_next;

    // flow control
    logic out_free;
    logic s2_adv;
    logic s2_free;
    logic s1_adv;

    logic signed [21:0] dx;
    logic signed [21:0] dy;
    logic signed [21:0] dz;
    logic signed [43:0] sqx;
    logic signed [43:0] sqy;
    logic signed [43:0] sqz;

    assign out_free = !out_valid_reg || m_tready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || s2_free;

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            center_z_reg   <= '0;
            radius_sq_reg  <= '0;
            hold_time_reg  <= '0;
            start_time_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wdd_pkg::REG_CENTER_X:   center_x_reg   <= cfg_wdata[20:0];
                wdd_pkg::REG_CENTER_Y:   center_y_reg   <= cfg_wdata[20:0];
                wdd_pkg::REG_CENTER_Z:   center_z_reg   <= cfg_wdata[20:0];
                wdd_pkg::REG_RADIUS:     radius_sq_reg  <= {20'd0, cfg_wdata[19:0]}
                                                         * {20'd0, cfg_wdata[19:0]};
                wdd_pkg::REG_HOLD_TIME:  hold_time_reg  <= cfg_wdata[23:0];
                wdd_pkg::REG_START_TIME: start_time_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage 1: capture the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_op_reg        <= s_tuser[0];
            s1_smp_valid_reg <= s_tuser[1];
            s1_x_reg         <= s_tdata[20:0];
            s1_y_reg         <= s_tdata[41:21];
            s1_z_reg         <= s_tdata[62:42];
            s1_time_reg      <= s_tdata[94:63];
        end
    end

    // stage 2: squared distance and elapsed time
    assign dx  = {s1_x_reg[20], s1_x_reg} - {center_x_reg[20], center_x_reg};
    assign dy  = {s1_y_reg[20], s1_y_reg} - {center_y_reg[20], center_y_reg};
    assign dz  = {s1_z_reg[20], s1_z_reg} - {center_z_reg[20], center_z_reg};
    assign sqx = dx * dx;
    assign sqy = dy * dy;
    assign sqz = dz * dz;

    always_comb
    begin
        s2_item_next              = '0;
        s2_item_next.operation    = s1_op_reg;
        s2_item_next.sample_valid = s1_smp_valid_reg;
        s2_item_next.sample_time  = s1_time_reg;
        s2_item_next.dist_squared = sqx + sqy + sqz;
        s2_item_next.elapsed      = {1'b0, s1_time_reg} - {1'b0, start_time_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    // stage 3: dwell tracking, state advances only as the item moves on
    wdd_dwell u_dwell (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold_time (hold_time_reg),
        .radius_sq (radius_sq_reg),
        .step      (s2_adv),
        .item      (s2_item_reg),
        .result    (out_res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.finish_time, out_res_reg.elapsed,
                       out_res_reg.hold_remaining, out_res_reg.dist_squared};
    assign m_tuser  = {out_res_reg.status, out_res_reg.reached};

    // a finished status always comes with reached set
    a_finished_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_res_reg.status == wdd_pkg::ST_FINISHED)) |-> out_res_reg.reached)
        else $error("finished status without reached");

    // reached means a positive latched finish time
    a_reached_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.reached) |->
        (!out_res_reg.finish_time[32] && (out_res_reg.finish_time != '0)))
        else $error("reached with non-positive finish time");

    // a cleared result carries all-zero payload
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_res_reg.status == wdd_pkg::ST_CLEARED)) |->
        ((m_tdata == '0) && !out_res_reg.reached))
        else $error("cleared result with nonzero payload");

    // an empty result register never blocks the input
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output");

endmodule

// ===== rtl/wdd_dwell.sv =====
// ----------------------------------------------------------------------------
// wdd_dwell: dwell timer and finish latch
// Holds the dwell entry time and the finish latch, decides the status of one
// item and updates the state when the item moves on.
// ----------------------------------------------------------------------------
module wdd_dwell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [23:0]        hold_time,
    input  logic [39:0]        radius_sq,
    input  logic               step,
    input  wdd_pkg::wdd_item_t item,
    output wdd_pkg::wdd_result_t result
);

    logic        first_reg;
    logic        first_next;
    logic [31:0] entry_reg;
    logic [31:0] entry_next;
    logic [32:0] latch_reg;
    logic [32:0] latch_next;

    logic [31:0] entry_eff;
    logic [33:0] span;
    logic [33:0] rem_raw;
    logic        in_sphere;
    logic        rem_le0;
    logic        latch_le0;
    logic [32:0] latch_cand;
    logic        finished;

    always_comb
    begin
        entry_eff  = first_reg ? item.sample_time : entry_reg;
        span       = {2'b00, item.sample_time} - {2'b00, entry_eff};
        rem_raw    = {10'd0, hold_time} - span;
        in_sphere  = item.dist_squared < {4'd0, radius_sq};
        rem_le0    = rem_raw[33] || (rem_raw == '0);
        latch_le0  = latch_reg[32] || (latch_reg == '0);
        latch_cand = (in_sphere && rem_le0 && latch_le0) ? item.elapsed : latch_reg;
        finished   = !latch_cand[32] && (latch_cand != '0);

        first_next = first_reg;
        entry_next = entry_reg;
        latch_next = latch_reg;

        result                = '0;
        result.status         = wdd_pkg::ST_CLEARED;

        if (item.operation == wdd_pkg::OP_CLEAR)
        begin
            latch_next = '0;
        end
        else
        begin
            first_next            = 1'b0;
            latch_next            = latch_cand;
            entry_next            = entry_eff;
            result.reached        = finished;
            result.dist_squared   = item.dist_squared;
            result.elapsed        = item.elapsed;
            result.finish_time    = latch_cand;
            result.hold_remaining = rem_raw;
            result.status         = in_sphere ? wdd_pkg::ST_INSIDE : wdd_pkg::ST_OUTSIDE;
            if (!in_sphere)
            begin
                // restart the dwell timer
                entry_next            = item.sample_time;
                result.hold_remaining = {10'd0, hold_time};
            end
            if (finished)
            begin
                result.status = wdd_pkg::ST_FINISHED;
            end
            else if (!item.sample_valid)
            begin
                entry_next            = item.sample_time;
                result.hold_remaining = {10'd0, hold_time};
                result.status         = wdd_pkg::ST_INVALID;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            entry_reg <= '0;
            latch_reg <= '0;
        end
        else if (step)
        begin
            first_reg <= first_next;
            entry_reg <= entry_next;
            latch_reg <= latch_next;
        end
    end

endmodule

// ===== sim/dwell_checker.sv =====
// ----------------------------------------------------------------------------
// dwell_checker: result predictor and comparator for the dwell detector
// Watches the configuration port and both item streams, keeps its own copy
// of the registers and the dwell state, predicts one result per accepted
// input item and compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module dwell_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,
    input  logic [3:0]   m_tuser,
    output int           n_pending,
    output int           n_fail,
    output int           n_checked
);

    // register copies
    logic signed [20:0] ctr_x, ctr_y, ctr_z;
    logic [19:0]        radius_q;
    logic [23:0]        hold_q;
    logic [31:0]        start_q;

    // dwell state
    logic               first_q;
    logic [31:0]        entry_q;
    longint             finish_q;

    wdd_pkg::wdd_result_t awaited_results[$];
    wdd_pkg::wdd_result_t want, got, fresh;
    int                   fail_tally;
    int                   checked_tally;

    function automatic wdd_pkg::wdd_result_t predict_dwell(
        input logic               op,
        input logic signed [20:0] px,
        input logic signed [20:0] py,
        input logic signed [20:0] pz,
        input logic [31:0]        t,
        input logic               v
    );
        wdd_pkg::wdd_result_t r;
        wdd_pkg::wdd_status_t st;
        longint               dx, dy, dz, d2, rem, el;
        r = '0;
        if (op == wdd_pkg::OP_CLEAR)
        begin
            finish_q = 0;
            r.status = wdd_pkg::ST_CLEARED;
            return r;
        end
        if (first_q)
        begin
            entry_q = t;
            first_q = 1'b0;
        end
        dx  = longint'(px) - longint'(ctr_x);
        dy  = longint'(py) - longint'(ctr_y);
        dz  = longint'(pz) - longint'(ctr_z);
        d2  = dx * dx + dy * dy + dz * dz;
        rem = longint'(hold_q) - (longint'(t) - longint'(entry_q));
        el  = longint'(t) - longint'(start_q);
        // inside means strictly closer than the radius
        if (d2 < longint'(radius_q) * longint'(radius_q))
        begin
            if (rem <= 0 && finish_q <= 0)
                finish_q = el;
            st = wdd_pkg::ST_INSIDE;
        end
        else
        begin
            entry_q = t;
            rem     = longint'(hold_q);
            st      = wdd_pkg::ST_OUTSIDE;
        end
        // the latch wins over validity, so an invalid sample inside can finish
        if (finish_q > 0)
            st = wdd_pkg::ST_FINISHED;
        else if (!v)
        begin
            entry_q = t;
            rem     = longint'(hold_q);
            st      = wdd_pkg::ST_INVALID;
        end
        r.reached        = (finish_q > 0);
        r.status         = st;
        r.dist_squared   = d2[43:0];
        r.hold_remaining = rem[33:0];
        r.elapsed        = el[32:0];
        r.finish_time    = finish_q[32:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            ctr_x    = '0;
            ctr_y    = '0;
            ctr_z    = '0;
            radius_q = '0;
            hold_q   = '0;
            start_q  = '0;
            first_q  = 1'b1;
            entry_q  = '0;
            finish_q = 0;
            awaited_results.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    wdd_pkg::REG_CENTER_X:   ctr_x    = cfg_wdata[20:0];
                    wdd_pkg::REG_CENTER_Y:   ctr_y    = cfg_wdata[20:0];
                    wdd_pkg::REG_CENTER_Z:   ctr_z    = cfg_wdata[20:0];
                    wdd_pkg::REG_RADIUS:     radius_q = cfg_wdata[19:0];
                    wdd_pkg::REG_HOLD_TIME:  hold_q   = cfg_wdata[23:0];
                    wdd_pkg::REG_START_TIME: start_q  = cfg_wdata;
                    default: ;
                endcase
            end
            // compare before pushing, so a result never matches the item
            // accepted on the same edge
            if (m_tvalid && m_tready)
            begin
                got.reached        = m_tuser[0];
                got.status         = wdd_pkg::wdd_status_t'(m_tuser[3:1]);
                got.dist_squared   = m_tdata[43:0];
                got.hold_remaining = m_tdata[77:44];
                got.elapsed        = m_tdata[110:78];
                got.finish_time    = m_tdata[143:111];
                if (awaited_results.size() == 0)
                begin
                    if (fail_tally < 10)
                        $display("checker: result %0d arrived with no item outstanding",
                                 checked_tally);
                    fail_tally++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got !== want)
                    begin
                        if (fail_tally < 10)
                        begin
                            $display("checker: result %0d want reached=%0b status=%0d",
                                     checked_tally, want.reached, want.status);
                            $display("  d2=%0d hold=%0d elapsed=%0d finish=%0d",
                                     want.dist_squared, $signed(want.hold_remaining),
                                     $signed(want.elapsed), $signed(want.finish_time));
                            $display("  got reached=%0b status=%0d d2=%0d",
                                     got.reached, got.status, got.dist_squared);
                            $display("  hold=%0d elapsed=%0d finish=%0d",
                                     $signed(got.hold_remaining), $signed(got.elapsed),
                                     $signed(got.finish_time));
                        end
                        fail_tally++;
                    end
                end
                checked_tally++;
            end
            if (s_tvalid && s_tready)
            begin
                fresh = predict_dwell(s_tuser[0], s_tdata[20:0], s_tdata[41:21],
                                      s_tdata[62:42], s_tdata[94:63], s_tuser[1]);
                awaited_results.insert(awaited_results.size(), fresh);
            end
        end
        n_pending <= awaited_results.size();
        n_fail    <= fail_tally;
        n_checked <= checked_tally;
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the waypoint dwell detector
// Drives a directed set of pose samples and clears through the sphere and
// timer corner cases, then random trajectories near the waypoint under
// several register settings and flow-control patterns. The checker beside
// the unit predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;

    localparam int QUIET_LIMIT  = 4000;  // cycles with no item moving
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
    localparam int PHASE_ITEMS  = 54;
    localparam int RANDOM_PHASES = 8;
    localparam int TAIL_CYCLES  = 8;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    // pos_x[20:0], pos_y[41:21], pos_z[62:42], sample_time[94:63], zero[95]
    logic [95:0]  s_tdata   = '0;
    // operation[0], sample_valid[1]
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    // dist_squared[43:0], hold_remaining[77:44], elapsed[110:78],
    // finish_time[143:111]
    logic [143:0] m_tdata;
    // reached[0], status[3:1]
    logic [3:0]   m_tuser;

    int n_pending, n_fail, n_checked;

    // flow control knobs, percent per cycle
    int          idle_pct   = 0;
    int          stall_pct  = 0;
    logic        hold_req   = 1'b0;
    logic        hold_taken = 1'b0;

    // current waypoint and trajectory time, mirrored for stimulus shaping
    int          cur_cx, cur_cy, cur_cz;
    int unsigned cur_rad;
    int unsigned step_max;
    logic [31:0] t_now;

    int n_sent     = 0;
    int n_clears   = 0;
    int n_settings = 0;
    int quiet;

    waypoint_dwell_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    dwell_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .n_pending (n_pending),
        .n_fail    (n_fail),
        .n_checked (n_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Saturate a coordinate into the 21-bit signed range.
    function automatic logic signed [20:0] clamp21(input longint v);
        if (v > 1048575)
            return 21'sh0F_FFFF;
        if (v < -1048576)
            return 21'sh10_0000;
        return v[20:0];
    endfunction

    // Write one register; the write lands on the next rising edge. Leave the
    // enable high so back-to-back writes need no gap.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // Program a full waypoint setting. Fill the bits above each register's
    // width with noise: the unit must drop them.
    task automatic program_regs(input int cx, input int cy, input int cz,
                                input int unsigned r, input int unsigned h,
                                input logic [31:0] st);
        write_reg(wdd_pkg::REG_CENTER_X,   {11'($urandom), 21'(cx)});
        write_reg(wdd_pkg::REG_CENTER_Y,   {11'($urandom), 21'(cy)});
        write_reg(wdd_pkg::REG_CENTER_Z,   {11'($urandom), 21'(cz)});
        write_reg(wdd_pkg::REG_RADIUS,     {12'($urandom), 20'(r)});
        write_reg(wdd_pkg::REG_HOLD_TIME,  {8'($urandom), 24'(h)});
        write_reg(wdd_pkg::REG_START_TIME, st);
        cfg_wr_en <= 1'b0;
        cur_cx  = cx;
        cur_cy  = cy;
        cur_cz  = cz;
        cur_rad = r;
        n_settings++;
    endtask

    // Offer one item and hold it until accepted, then maybe idle a while.
    task automatic send_item(input logic op, input logic signed [20:0] px,
                             input logic signed [20:0] py,
                             input logic signed [20:0] pz,
                             input logic [31:0] t, input logic v);
        s_tdata  <= {1'b0, t, pz, py, px};
        s_tuser  <= {v, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
        if (op == wdd_pkg::OP_CLEAR)
            n_clears++;
        if ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Stop offering and wait until every predicted result has come back.
    // The pending count is registered, so look at it only after the next edge.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
    endtask

    // One random item, mostly a trajectory around the waypoint with time
    // moving forward, plus clears, off-sphere samples and raw noise.
    task automatic random_item();
        int unsigned pick;
        int          lim;
        longint      ox, oy, oz;
        logic        v;
        pick  = $urandom_range(99);
        lim   = cur_rad / 2;
        t_now = t_now + $urandom_range(0, step_max);
        v     = ($urandom_range(99) >= 10);
        if (pick < 5)
            send_item(wdd_pkg::OP_CLEAR, 21'($urandom), 21'($urandom), 21'($urandom),
                      $urandom, 1'($urandom));
        else if (pick < 15)
            send_item(wdd_pkg::OP_SAMPLE, 21'($urandom), 21'($urandom), 21'($urandom),
                      $urandom, 1'($urandom));
        else if (pick < 22)
        begin
            // exactly on the sphere surface along x: must count as outside
            ox = $urandom_range(1) ? longint'(cur_rad) : -longint'(cur_rad);
            send_item(wdd_pkg::OP_SAMPLE, clamp21(cur_cx + ox), clamp21(cur_cy),
                      clamp21(cur_cz), t_now, v);
        end
        else if (pick < 30)
        begin
            ox = longint'(cur_rad) + 1 + $urandom_range(0, 5000);
            if ($urandom_range(1))
                ox = -ox;
            send_item(wdd_pkg::OP_SAMPLE, clamp21(cur_cx + ox), clamp21(cur_cy),
                      clamp21(cur_cz + longint'($urandom_range(0, 100))), t_now, v);
        end
        else
        begin
            ox = longint'($urandom_range(0, 2 * lim)) - lim;
            oy = longint'($urandom_range(0, 2 * lim)) - lim;
            oz = longint'($urandom_range(0, 2 * lim)) - lim;
            send_item(wdd_pkg::OP_SAMPLE, clamp21(cur_cx + ox), clamp21(cur_cy + oy),
                      clamp21(cur_cz + oz), t_now, v);
        end
    endtask

    // Pick a register setting for one random phase, forcing the extremes
    // on a few phases.
    task automatic random_setting(input int phase);
        int          cx, cy, cz;
        int unsigned r, h;
        logic [31:0] st;
        cx = $signed(21'($urandom));
        cy = $signed(21'($urandom));
        cz = $signed(21'($urandom));
        case ($urandom_range(2))
            0:       r = $urandom_range(1, 64);
            1:       r = $urandom_range(65, 5000);
            default: r = $urandom_range(5001, 1048575);
        endcase
        h     = $urandom_range(0, 400);
        t_now = $urandom;
        case (phase)
            0:
            begin
                cx = 1048575;
                cy = 1048575;
                cz = 1048575;
                r  = 1048575;
            end
            1:
            begin
                cx = -1048576;
                cy = -1048576;
                cz = -1048576;
            end
            2:       t_now = 32'hFFFF_FF00;  // run timestamps across the wrap
            3:       h = 24'hFF_FFFF;
            5:       h = 0;
            6:       r = 0;                  // nothing can be inside
            default: ;
        endcase
        if (phase == 7)
            st = $urandom;                   // elapsed of either sign
        else
            st = t_now - $urandom_range(0, 5000);
        step_max = h / 4 + 1;
        program_regs(cx, cy, cz, r, h, st);
    endtask

    // Receiver: stall at random, or hold off once for a long stretch on
    // request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                m_tready   <= 1'b0;
                hold_taken = 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run if no item moves on either side for too long.
    initial
    begin
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, n_pending);
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Dwell, finish, clear, and the invalid-but-inside latch.
        program_regs(100, -200, 300, 1000, 50, 1000);
        // first sample starts the timer
        send_item(wdd_pkg::OP_SAMPLE, 100, -200, 300, 2000, 1'b1);
        send_item(wdd_pkg::OP_SAMPLE, 150, -200, 300, 2030, 1'b1);
        // on the surface: outside
        send_item(wdd_pkg::OP_SAMPLE, 100, 800, 300, 2040, 1'b1);
        // hold runs out: finished
        send_item(wdd_pkg::OP_SAMPLE, 100, -200, 300, 2090, 1'b1);
        send_item(wdd_pkg::OP_SAMPLE, 1048575, 1048575, 1048575, 2100, 1'b1);
        send_item(wdd_pkg::OP_CLEAR, -1, -1, -1, 32'hFFFF_FFFF, 1'b1);
        send_item(wdd_pkg::OP_SAMPLE, 5000, 0, 0, 2110, 1'b0);       // invalid outside
        send_item(wdd_pkg::OP_SAMPLE, 100, -200, 300, 2120, 1'b0);   // invalid inside
        // invalid inside latches
        send_item(wdd_pkg::OP_SAMPLE, 100, -200, 300, 2200, 1'b0);
        send_item(wdd_pkg::OP_CLEAR, 0, 0, 0, 0, 1'b0);
        drain();

        // Extreme centre and radius, zero hold, start at the top of time:
        // the latch takes zero and negative values, which do not count.
        program_regs(-1048576, 1048575, -1048576, 1048575, 0, 32'hFFFF_FFFF);
        send_item(wdd_pkg::OP_SAMPLE, 1048575, -1048576, 1048575, 0, 1'b1);
        send_item(wdd_pkg::OP_SAMPLE, -1048576, 1048575, -1048576, 32'hFFFF_FFFF, 1'b1);
        send_item(wdd_pkg::OP_SAMPLE, -1048576, 1048575, -1048576, 5, 1'b1);
        send_item(wdd_pkg::OP_SAMPLE, -1, 1048575, -1048576, 100, 1'b1);
        send_item(wdd_pkg::OP_SAMPLE, -2, 1048575, -1048576, 32'h8000_0000, 1'b1);
        drain();

        // Longest hold: push the remaining time to its top, then sample inside again, still short of the hold.
        program_regs(0, 0, 0, 1048575, 24'hFF_FFFF, 0);
        send_item(wdd_pkg::OP_SAMPLE, 1048575, 1048575, 1048575, 32'hFFFF_FFFF, 1'b1);
        send_item(wdd_pkg::OP_SAMPLE, 0, 0, 0, 0, 1'b1);
        send_item(wdd_pkg::OP_SAMPLE, 0, 0, 0, 32'h0100_0000, 1'b1);
        send_item(wdd_pkg::OP_CLEAR, 21'h0AAAAA, 21'h155555, 21'h1FFFFF, 32'h5555_AAAA,
                  1'b1);
        drain();

        // Zero radius: even the centre is outside.
        program_regs(12345, -54321, 777, 0, 10, 500);
        send_item(wdd_pkg::OP_SAMPLE, 12345, -54321, 777, 600, 1'b1);
        send_item(wdd_pkg::OP_SAMPLE, 12345, -54321, 777, 700, 1'b0);
        send_item(wdd_pkg::OP_CLEAR, 21'($urandom), 21'($urandom), 21'($urandom),
                  $urandom, 1'b0);
        drain();

        // Random phases, cycling through the flow-control patterns.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 70;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 70;
                end
                default:
                begin
                    idle_pct = 34;
                    stall_pct <= 34;
                end
            endcase
            random_setting(phase);
            // fill the pipeline against a long receiver hold-off
            if (phase == 4)
                hold_req <= 1'b1;
            repeat (PHASE_ITEMS)
                random_item();
            drain();
        end

        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("summary: %0d items (%0d clears) under %0d register settings,",
                 n_sent, n_clears, n_settings);
        $display("summary: %0d results compared, %0d mismatches", n_checked, n_fail);
        if (n_fail == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
